/* sv/cau_pkg.sv */
// Shared types and constants for the complex arithmetic unit.
// Holds the request/response payloads, operation and status codes, and the pipeline tag.
// No dependencies.
package cau_pkg;

    localparam int CAU_DATA_W    = 16;
    localparam int CAU_FRAC_BITS = 8;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_MAG = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_SAT  = 2'd1,
        ST_DIVZ = 2'd2
    } t_status;

    typedef struct packed {
        logic [2:0]                   operation;
        logic signed [CAU_DATA_W-1:0] left_real;
        logic signed [CAU_DATA_W-1:0] left_imag;
        logic signed [CAU_DATA_W-1:0] right_real;
        logic signed [CAU_DATA_W-1:0] right_imag;
    } t_req;

    typedef struct packed {
        logic signed [CAU_DATA_W-1:0] result_real;
        logic signed [CAU_DATA_W-1:0] result_imag;
        logic [1:0]                   status;
    } t_rsp;

    typedef struct packed {
        logic       valid;
        logic [2:0] op;
        logic       fast_sat;
        logic       div_zero;
        logic       ovf_re;
        logic       ovf_im;
        logic       neg_re;
        logic       neg_im;
    } t_tag;

endpackage

/* sv/cau_front.sv */
// Front end of the complex arithmetic unit: operand capture, products, sums, rounding.
// Finishes add, subtract and multiply; prepares divider and square-root operands.
// Depends on cau_pkg.
module cau_front
    import cau_pkg::*;
#(
    parameter int FRAC_BITS = CAU_FRAC_BITS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_adv,
    input  logic                      i_valid,
    input  t_req                      i_req,
    output t_tag                      o_tag,
    output logic [CAU_DATA_W-1:0]     o_fast_re,
    output logic [CAU_DATA_W-1:0]     o_fast_im,
    output logic [2*CAU_DATA_W:0]     o_den,
    output logic [2*CAU_DATA_W:0]     o_rem_re,
    output logic [2*CAU_DATA_W:0]     o_rem_im,
    output logic [CAU_DATA_W:0]       o_dvd_re,
    output logic [CAU_DATA_W:0]       o_dvd_im,
    output logic [2*CAU_DATA_W+1:0]   o_sq
);

    localparam int W    = CAU_DATA_W;
    localparam int NW   = 2 * W + 1;
    localparam int K    = W + 1;
    localparam int DW   = NW + FRAC_BITS + 1;
    localparam logic [NW-1:0] HALF = (FRAC_BITS > 0) ? (NW'(1) << (FRAC_BITS - 1)) : '0;

    function automatic logic [W:0] f_sat(input logic neg, input logic [NW-1:0] mag);
        logic [NW-1:0] lim;
        logic [NW-1:0] neg_mag;
        logic [W:0]    res;
        lim     = NW'(1) << (W - 1);
        neg_mag = '0 - mag;
        if (neg) begin
            if (mag > lim) res = {1'b1, 1'b1, {(W-1){1'b0}}};
            else           res = {1'b0, neg_mag[W-1:0]};
        end else begin
            if (mag > lim - NW'(1)) res = {1'b1, 1'b0, {(W-1){1'b1}}};
            else                    res = {1'b0, mag[W-1:0]};
        end
        return res;
    endfunction

    // stage 1: capture
    logic r1_v;
    t_req r1_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (i_adv) begin
            r1_v <= i_valid;
        end
        if (i_adv) begin
            r1_req <= i_req;
        end
    end

    // stage 2: products, add/subtract
    logic signed [W-1:0] a, b, c, d;
    logic signed [W:0]   ae, be, ce, de, n_s_re, n_s_im;
    logic [NW-1:0]       m_re, m_im;
    logic [W:0]          sat_re, sat_im;

    assign a  = r1_req.left_real;
    assign b  = r1_req.left_imag;
    assign c  = r1_req.right_real;
    assign d  = r1_req.right_imag;
    assign ae = a;
    assign be = b;
    assign ce = c;
    assign de = d;

    always_comb begin
        if (t_op'(r1_req.operation) == OP_SUB) begin
            n_s_re = ae - ce;
            n_s_im = be - de;
        end else begin
            n_s_re = ae + ce;
            n_s_im = be + de;
        end
        m_re   = NW'(n_s_re[W] ? 0 - n_s_re : n_s_re);
        m_im   = NW'(n_s_im[W] ? 0 - n_s_im : n_s_im);
        m_re   = NW'(m_re[W:0]);
        m_im   = NW'(m_im[W:0]);
        sat_re = f_sat(n_s_re[W], m_re);
        sat_im = f_sat(n_s_im[W], m_im);
    end

    logic                  r2_v;
    logic [2:0]            r2_op;
    logic signed [2*W-1:0] r2_ac, r2_bd, r2_bc, r2_ad, r2_cc, r2_dd, r2_aa, r2_bb;
    logic [W-1:0]          r2_fre, r2_fim;
    logic                  r2_fsat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (i_adv) begin
            r2_v <= r1_v;
        end
        if (i_adv) begin
            r2_op   <= r1_req.operation;
            r2_ac   <= a * c;
            r2_bd   <= b * d;
            r2_bc   <= b * c;
            r2_ad   <= a * d;
            r2_cc   <= c * c;
            r2_dd   <= d * d;
            r2_aa   <= a * a;
            r2_bb   <= b * b;
            r2_fre  <= sat_re[W-1:0];
            r2_fim  <= sat_im[W-1:0];
            r2_fsat <= sat_re[W] | sat_im[W];
        end
    end

    // stage 3: sums
    logic signed [NW-1:0] ac_e, bd_e, bc_e, ad_e, cc_e, dd_e, aa_e, bb_e;
    assign ac_e = r2_ac;
    assign bd_e = r2_bd;
    assign bc_e = r2_bc;
    assign ad_e = r2_ad;
    assign cc_e = r2_cc;
    assign dd_e = r2_dd;
    assign aa_e = r2_aa;
    assign bb_e = r2_bb;

    logic                 r3_v;
    logic [2:0]           r3_op;
    logic signed [NW-1:0] r3_mre, r3_mim, r3_dre, r3_dim;
    logic [NW-1:0]        r3_den, r3_sq;
    logic [W-1:0]         r3_fre, r3_fim;
    logic                 r3_fsat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (i_adv) begin
            r3_v <= r2_v;
        end
        if (i_adv) begin
            r3_op   <= r2_op;
            r3_mre  <= ac_e - bd_e;
            r3_mim  <= bc_e + ad_e;
            r3_dre  <= ac_e + bd_e;
            r3_dim  <= bc_e - ad_e;
            r3_den  <= cc_e + dd_e;
            r3_sq   <= aa_e + bb_e;
            r3_fre  <= r2_fre;
            r3_fim  <= r2_fim;
            r3_fsat <= r2_fsat;
        end
    end

    // stage 4: multiply rounding, divider setup
    logic [NW-1:0] mm_re, mm_im, rnd_re, rnd_im, dm_re, dm_im;
    logic [W:0]    msat_re, msat_im;
    logic [DW-1:0] dv_re, dv_im, top_re, top_im;
    logic          ov_re, ov_im;

    always_comb begin
        mm_re   = r3_mre[NW-1] ? NW'(0) - r3_mre : r3_mre;
        mm_im   = r3_mim[NW-1] ? NW'(0) - r3_mim : r3_mim;
        rnd_re  = (mm_re + HALF) >> FRAC_BITS;
        rnd_im  = (mm_im + HALF) >> FRAC_BITS;
        msat_re = f_sat(r3_mre[NW-1] && (mm_re != '0), rnd_re);
        msat_im = f_sat(r3_mim[NW-1] && (mm_im != '0), rnd_im);
        dm_re   = r3_dre[NW-1] ? NW'(0) - r3_dre : r3_dre;
        dm_im   = r3_dim[NW-1] ? NW'(0) - r3_dim : r3_dim;
        dv_re   = {dm_re, {(FRAC_BITS+1){1'b0}}};
        dv_im   = {dm_im, {(FRAC_BITS+1){1'b0}}};
        top_re  = dv_re >> K;
        top_im  = dv_im >> K;
        ov_re   = top_re >= DW'(r3_den);
        ov_im   = top_im >= DW'(r3_den);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_tag <= '0;
        end else if (i_adv) begin
            o_tag.valid    <= r3_v;
            o_tag.op       <= r3_op;
            o_tag.div_zero <= r3_den == '0;
            o_tag.ovf_re   <= ov_re;
            o_tag.ovf_im   <= ov_im;
            o_tag.neg_re   <= r3_dre[NW-1];
            o_tag.neg_im   <= r3_dim[NW-1];
            o_tag.fast_sat <= (t_op'(r3_op) == OP_MUL) ? (msat_re[W] | msat_im[W]) : r3_fsat;
        end
        if (i_adv) begin
            o_fast_re <= (t_op'(r3_op) == OP_MUL) ? msat_re[W-1:0] : r3_fre;
            o_fast_im <= (t_op'(r3_op) == OP_MUL) ? msat_im[W-1:0] : r3_fim;
            o_den     <= r3_den;
            o_rem_re  <= ov_re ? '0 : top_re[NW-1:0];
            o_rem_im  <= ov_im ? '0 : top_im[NW-1:0];
            o_dvd_re  <= dv_re[K-1:0];
            o_dvd_im  <= dv_im[K-1:0];
            o_sq      <= (2*K)'(r3_sq);
        end
    end

endmodule

/* sv/cau_cell.sv */
// One cell of the quotient/root chain: one restoring divide step per lane
// and one square-root digit step, registered. Depends on cau_pkg.
module cau_cell
    import cau_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_adv,
    input  t_tag                    i_tag,
    input  logic [CAU_DATA_W-1:0]   i_fast_re,
    input  logic [CAU_DATA_W-1:0]   i_fast_im,
    input  logic [2*CAU_DATA_W:0]   i_den,
    input  logic [2*CAU_DATA_W:0]   i_rem_re,
    input  logic [2*CAU_DATA_W:0]   i_rem_im,
    input  logic [CAU_DATA_W:0]     i_dvd_re,
    input  logic [CAU_DATA_W:0]     i_dvd_im,
    input  logic [CAU_DATA_W:0]     i_q_re,
    input  logic [CAU_DATA_W:0]     i_q_im,
    input  logic [2*CAU_DATA_W+1:0] i_sq,
    input  logic [CAU_DATA_W+2:0]   i_xrem,
    input  logic [CAU_DATA_W:0]     i_root,
    output t_tag                    o_tag,
    output logic [CAU_DATA_W-1:0]   o_fast_re,
    output logic [CAU_DATA_W-1:0]   o_fast_im,
    output logic [2*CAU_DATA_W:0]   o_den,
    output logic [2*CAU_DATA_W:0]   o_rem_re,
    output logic [2*CAU_DATA_W:0]   o_rem_im,
    output logic [CAU_DATA_W:0]     o_dvd_re,
    output logic [CAU_DATA_W:0]     o_dvd_im,
    output logic [CAU_DATA_W:0]     o_q_re,
    output logic [CAU_DATA_W:0]     o_q_im,
    output logic [2*CAU_DATA_W+1:0] o_sq,
    output logic [CAU_DATA_W+2:0]   o_xrem,
    output logic [CAU_DATA_W:0]     o_root
);

    localparam int W  = CAU_DATA_W;
    localparam int RW = 2 * W + 1;
    localparam int K  = W + 1;
    localparam int XW = W + 3;

    logic [RW-1:0] t_re, t_im;
    logic          ge_re, ge_im, ge_sq;
    logic [XW-1:0] st, trial;

    always_comb begin
        t_re  = {i_rem_re[RW-2:0], i_dvd_re[K-1]};
        t_im  = {i_rem_im[RW-2:0], i_dvd_im[K-1]};
        ge_re = t_re >= i_den;
        ge_im = t_im >= i_den;
        st    = {i_xrem[XW-3:0], i_sq[2*K-1:2*K-2]};
        trial = {i_root, 2'b01};
        ge_sq = st >= trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_tag <= '0;
        end else if (i_adv) begin
            o_tag <= i_tag;
        end
        if (i_adv) begin
            o_fast_re <= i_fast_re;
            o_fast_im <= i_fast_im;
            o_den     <= i_den;
            o_rem_re  <= ge_re ? t_re - i_den : t_re;
            o_rem_im  <= ge_im ? t_im - i_den : t_im;
            o_dvd_re  <= {i_dvd_re[K-2:0], 1'b0};
            o_dvd_im  <= {i_dvd_im[K-2:0], 1'b0};
            o_q_re    <= {i_q_re[K-2:0], ge_re};
            o_q_im    <= {i_q_im[K-2:0], ge_im};
            o_sq      <= {i_sq[2*K-3:0], 2'b00};
            o_xrem    <= ge_sq ? st - trial : st;
            o_root    <= {i_root[K-2:0], ge_sq};
        end
    end

endmodule

/* sv/cau_back.sv */
// Back end of the complex arithmetic unit: quotient and root rounding,
// saturation, result selection and the output register. Depends on cau_pkg.
module cau_back
    import cau_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_adv,
    input  t_tag                  i_tag,
    input  logic [CAU_DATA_W-1:0] i_fast_re,
    input  logic [CAU_DATA_W-1:0] i_fast_im,
    input  logic [CAU_DATA_W:0]   i_q_re,
    input  logic [CAU_DATA_W:0]   i_q_im,
    input  logic [CAU_DATA_W+2:0] i_xrem,
    input  logic [CAU_DATA_W:0]   i_root,
    output logic                  o_valid,
    output t_rsp                  o_rsp
);

    localparam int W  = CAU_DATA_W;
    localparam int K  = W + 1;
    localparam int XW = W + 3;

    function automatic logic [W:0] f_sat(input logic neg, input logic [K:0] mag);
        logic [K:0] lim;
        logic [K:0] neg_mag;
        logic [W:0] res;
        lim     = (K+1)'(1) << (W - 1);
        neg_mag = '0 - mag;
        if (neg) begin
            if (mag > lim) res = {1'b1, 1'b1, {(W-1){1'b0}}};
            else           res = {1'b0, neg_mag[W-1:0]};
        end else begin
            if (mag > lim - (K+1)'(1)) res = {1'b1, 1'b0, {(W-1){1'b1}}};
            else                       res = {1'b0, mag[W-1:0]};
        end
        return res;
    endfunction

    logic [K-1:0] qf_re, qf_im;
    logic [K:0]   fin_re, fin_im, rt;
    logic [W:0]   ds_re, ds_im, ms;
    t_rsp         n_rsp;

    always_comb begin
        qf_re  = i_tag.ovf_re ? '1 : i_q_re;
        qf_im  = i_tag.ovf_im ? '1 : i_q_im;
        fin_re = ({1'b0, qf_re} + (K+1)'(1)) >> 1;
        fin_im = ({1'b0, qf_im} + (K+1)'(1)) >> 1;
        ds_re  = f_sat(i_tag.neg_re && (fin_re != '0), fin_re);
        ds_im  = f_sat(i_tag.neg_im && (fin_im != '0), fin_im);
        rt     = {1'b0, i_root} + (K+1)'(i_xrem > XW'(i_root));
        ms     = f_sat(1'b0, rt);
        n_rsp  = '0;
        unique case (t_op'(i_tag.op))
            OP_ADD, OP_SUB, OP_MUL: begin
                n_rsp.result_real = i_fast_re;
                n_rsp.result_imag = i_fast_im;
                n_rsp.status      = i_tag.fast_sat ? ST_SAT : ST_OK;
            end
            OP_DIV: begin
                if (i_tag.div_zero) begin
                    n_rsp.status = ST_DIVZ;
                end else begin
                    n_rsp.result_real = ds_re[W-1:0];
                    n_rsp.result_imag = ds_im[W-1:0];
                    n_rsp.status      = (ds_re[W] | ds_im[W]) ? ST_SAT : ST_OK;
                end
            end
            OP_MAG: begin
                n_rsp.result_real = ms[W-1:0];
                n_rsp.status      = ms[W] ? ST_SAT : ST_OK;
            end
            default: begin
                n_rsp = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_adv) begin
            o_valid <= i_tag.valid;
        end
        if (i_adv) begin
            o_rsp <= n_rsp;
        end
    end

endmodule

/* sv/complex_arithmetic_unit.sv */
// Complex arithmetic unit: add, subtract, multiply, divide and magnitude in signed Q7.8.
// Top level; instantiates cau_front, a chain of cau_cell and cau_back. Depends on cau_pkg.
//
// Usage:
//   Requests enter on i_valid/i_req and are taken at an edge where o_stall is low.
//   Results leave on o_valid/o_rsp and are taken at an edge where i_stall is low.
//   Every request gives exactly one result, in request order.
//   The pipeline has four front stages, one cell per quotient/root bit (DATA_WIDTH + 1
//   cells), and the output register.
//   Throughput is one request per cycle while no result waits under i_stall; the cell chain
//   retires one quotient bit per lane and one root digit per cell, so every operation takes the same path.
//   While a result waits under i_stall, the whole pipeline holds and o_stall is raised;
//   the next request is taken in the cycle the result leaves.
//   Reset clears all valid flags; the pipeline is empty the cycle after reset.
//   Division by zero returns zero with status 2; overflow saturates with status 1.
//   Unused operation codes return zero with status 0.
module complex_arithmetic_unit
    import cau_pkg::*;
#(
    parameter int FRAC_BITS = CAU_FRAC_BITS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_req i_req,
    output logic o_valid,
    input  logic i_stall,
    output t_rsp o_rsp
);

    localparam int W  = CAU_DATA_W;
    localparam int K  = W + 1;
    localparam int RW = 2 * W + 1;
    localparam int XW = W + 3;

    logic adv;
    assign adv     = !o_valid || !i_stall;
    assign o_stall = !adv;

    t_tag          w_tag    [0:K];
    logic [W-1:0]  w_fre    [0:K];
    logic [W-1:0]  w_fim    [0:K];
    logic [RW-1:0] w_den    [0:K];
    logic [RW-1:0] w_rre    [0:K];
    logic [RW-1:0] w_rim    [0:K];
    logic [K-1:0]  w_dre    [0:K];
    logic [K-1:0]  w_dim    [0:K];
    logic [K-1:0]  w_qre    [0:K];
    logic [K-1:0]  w_qim    [0:K];
    logic [2*K-1:0] w_sq    [0:K];
    logic [XW-1:0] w_xrem   [0:K];
    logic [K-1:0]  w_root   [0:K];

    cau_front #(
        .FRAC_BITS(FRAC_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_valid  (i_valid),
        .i_req    (i_req),
        .o_tag    (w_tag[0]),
        .o_fast_re(w_fre[0]),
        .o_fast_im(w_fim[0]),
        .o_den    (w_den[0]),
        .o_rem_re (w_rre[0]),
        .o_rem_im (w_rim[0]),
        .o_dvd_re (w_dre[0]),
        .o_dvd_im (w_dim[0]),
        .o_sq     (w_sq[0])
    );

    assign w_qre[0]  = '0;
    assign w_qim[0]  = '0;
    assign w_xrem[0] = '0;
    assign w_root[0] = '0;

    for (genvar g = 0; g < K; g++) begin : g_cell
        cau_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_adv    (adv),
            .i_tag    (w_tag[g]),
            .i_fast_re(w_fre[g]),
            .i_fast_im(w_fim[g]),
            .i_den    (w_den[g]),
            .i_rem_re (w_rre[g]),
            .i_rem_im (w_rim[g]),
            .i_dvd_re (w_dre[g]),
            .i_dvd_im (w_dim[g]),
            .i_q_re   (w_qre[g]),
            .i_q_im   (w_qim[g]),
            .i_sq     (w_sq[g]),
            .i_xrem   (w_xrem[g]),
            .i_root   (w_root[g]),
            .o_tag    (w_tag[g+1]),
            .o_fast_re(w_fre[g+1]),
            .o_fast_im(w_fim[g+1]),
            .o_den    (w_den[g+1]),
            .o_rem_re (w_rre[g+1]),
            .o_rem_im (w_rim[g+1]),
            .o_dvd_re (w_dre[g+1]),
            .o_dvd_im (w_dim[g+1]),
            .o_q_re   (w_qre[g+1]),
            .o_q_im   (w_qim[g+1]),
            .o_sq     (w_sq[g+1]),
            .o_xrem   (w_xrem[g+1]),
            .o_root   (w_root[g+1])
        );
    end

    cau_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_tag    (w_tag[K]),
        .i_fast_re(w_fre[K]),
        .i_fast_im(w_fim[K]),
        .i_q_re   (w_qre[K]),
        .i_q_im   (w_qim[K]),
        .i_xrem   (w_xrem[K]),
        .i_root   (w_root[K]),
        .o_valid  (o_valid),
        .o_rsp    (o_rsp)
    );

endmodule

/* sv/cau_checker.sv */
// Port-level checks for the complex arithmetic unit, bound to the top level.
// Depends on cau_pkg and complex_arithmetic_unit.
module cau_checker
    import cau_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_stall,
    input t_req i_req,
    input logic o_valid,
    input logic i_stall,
    input t_rsp o_rsp
);

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_rsp))
        else $error("response changed while stalled");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("request stalled without a waiting response");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_rsp.status == ST_OK || o_rsp.status == ST_SAT
                    || o_rsp.status == ST_DIVZ)
        else $error("undefined status code");

    a_divz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_rsp.status == ST_DIVZ |-> o_rsp.result_real == '0
                                              && o_rsp.result_imag == '0)
        else $error("division by zero with nonzero result");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("response valid after reset");

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (.*);

/* tb/sv/tb_complex_arithmetic_unit.sv */
// Self-checking testbench for complex_arithmetic_unit: random and directed requests,
// predicted results queued in order and compared against every accepted response.
// Depends on cau_pkg and the complex_arithmetic_unit RTL.
module tb_complex_arithmetic_unit;
    import cau_pkg::*;

    localparam int W = CAU_DATA_W;
    localparam int FB = CAU_FRAC_BITS;
    localparam longint LIM = 64'sd1 <<< (W - 1);

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    t_req i_req;
    logic o_valid;
    logic i_stall;
    t_rsp o_rsp;

    complex_arithmetic_unit i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_req(i_req), .o_valid(o_valid), .i_stall(i_stall), .o_rsp(o_rsp)
    );

    t_req   pending_reqs[$];
    t_rsp   expected_rsps[$];
    int     mismatches = 0;
    bit     gen_done = 0;
    bit     quiet_phase = 0;
    int     hold_cycles = 0;
    int     src_pause = 0;
    longint cycle = 0;

    function automatic logic [W-1:0] clamp(longint v, inout bit sat);
        if (v > LIM - 1) begin
            sat = 1;
            return W'(LIM - 1);
        end
        if (v < -LIM) begin
            sat = 1;
            return W'(-LIM);
        end
        return v[W-1:0];
    endfunction

    function automatic longint round_frac(longint v);
        longint m;
        m = v < 0 ? -v : v;
        m = (m + (64'sd1 <<< (FB - 1))) >>> FB;
        return v < 0 ? -m : m;
    endfunction

    // round(num * 2^FB / den), ties away from zero; widths fit in 64 bits for Q7.8
    function automatic longint div_frac(longint num, longint den);
        longint m, q;
        m = num < 0 ? -num : num;
        q = ((m <<< (FB + 1)) / den + 1) >>> 1;
        return num < 0 ? -q : q;
    endfunction

    function automatic longint root_round(longint s);
        longint r;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            if ((r + (64'sd1 <<< b)) * (r + (64'sd1 <<< b)) <= s)
                r = r + (64'sd1 <<< b);
        end
        if (s - r * r > r)
            r++;
        return r;
    endfunction

    function automatic t_rsp complex_result(t_req q);
        t_rsp   r;
        bit     sat;
        longint a, b, c, d, den;
        a = q.left_real;
        b = q.left_imag;
        c = q.right_real;
        d = q.right_imag;
        sat = 0;
        r = '0;
        case (q.operation)
            OP_ADD: begin
                r.result_real = clamp(a + c, sat);
                r.result_imag = clamp(b + d, sat);
            end
            OP_SUB: begin
                r.result_real = clamp(a - c, sat);
                r.result_imag = clamp(b - d, sat);
            end
            OP_MUL: begin
                r.result_real = clamp(round_frac(a * c - b * d), sat);
                r.result_imag = clamp(round_frac(b * c + a * d), sat);
            end
            OP_DIV: begin
                den = c * c + d * d;
                if (den != 0) begin
                    r.result_real = clamp(div_frac(a * c + b * d, den), sat);
                    r.result_imag = clamp(div_frac(b * c - a * d, den), sat);
                end
            end
            OP_MAG: r.result_real = clamp(root_round(a * a + b * b), sat);
            default: ;
        endcase
        if (q.operation == OP_DIV && c == 0 && d == 0)
            r.status = ST_DIVZ;
        else if (sat)
            r.status = ST_SAT;
        else
            r.status = ST_OK;
        return r;
    endfunction

    function automatic logic [W-1:0] pick_part();
        case ($urandom_range(0, 9))
            0: return W'(LIM - 1);
            1: return W'(-LIM);
            2: return '0;
            3: return $urandom_range(0, 1) ? 16'h0100 : 16'hff00;
            4: return W'($urandom_range(0, 31) - 16);
            default: return W'($urandom);
        endcase
    endfunction

    function automatic t_req random_req();
        t_req q;
        q.operation = 3'($urandom_range(0, 19) == 0 ? $urandom_range(5, 7)
                                                    : $urandom_range(0, 4));
        q.left_real = pick_part();
        q.left_imag = pick_part();
        q.right_real = pick_part();
        q.right_imag = pick_part();
        if ($urandom_range(0, 15) == 0) begin
            q.right_real = '0;
            q.right_imag = '0;
        end
        return q;
    endfunction

    function automatic t_req make_req(logic [2:0] op, longint a, longint b, longint c,
                                      longint d);
        t_req q;
        q.operation = op;
        q.left_real = W'(a);
        q.left_imag = W'(b);
        q.right_real = W'(c);
        q.right_imag = W'(d);
        return q;
    endfunction

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
    end

    initial begin
        for (int op = 0; op < 8; op++) begin
            pending_reqs.push_back(make_req(3'(op), 32767, -32768, 32767, -32768));
            pending_reqs.push_back(make_req(3'(op), 256, 512, 256, -256));
        end
        pending_reqs.push_back(make_req(OP_DIV, 1000, -1000, 0, 0));
        pending_reqs.push_back(make_req(OP_DIV, 32767, 32767, 1, 0));
        pending_reqs.push_back(make_req(OP_MUL, -32768, -32768, -32768, -32768));
        pending_reqs.push_back(make_req(OP_MAG, -32768, -32768, 0, 0));
        pending_reqs.push_back(make_req(OP_MUL, 1, 0, 128, 0));
        pending_reqs.push_back(make_req(OP_MUL, -1, 0, 128, 0));
        pending_reqs.push_back(make_req(OP_MAG, 0, 0, 5, 5));
        for (int i = 0; i < 1950; i++)
            pending_reqs.push_back(random_req());
        gen_done = 1;
    end

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 0;
            i_req <= '0;
        end else if (!(i_valid && o_stall)) begin
            if (cycle >= 1500 && src_pause == 0)
                src_pause = 1;
            if (src_pause == 1 && expected_rsps.size() == 0)
                src_pause = 2;
            if (pending_reqs.size() > 0 && src_pause != 1 &&
                (quiet_phase || $urandom_range(0, 99) >= 19)) begin
                i_req <= pending_reqs[0];
                expected_rsps.push_back(complex_result(pending_reqs.pop_front()));
                i_valid <= 1;
            end else begin
                i_valid <= 0;
                i_req <= $bits(t_req)'({$urandom, $urandom, $urandom});
            end
        end
    end

    // receiver stall and phase control
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 0;
        end else begin
            cycle <= cycle + 1;
            quiet_phase <= cycle >= 900 && cycle < 1400;
            if (cycle == 600)
                hold_cycles <= 200;
            else if (hold_cycles > 0)
                hold_cycles <= hold_cycles - 1;
            i_stall <= (cycle == 599 || hold_cycles > 1) ? 1 :
                       (quiet_phase ? 0 : $urandom_range(0, 99) < 19);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_rsp e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_rsps.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", o_rsp);
            end else begin
                e = expected_rsps.pop_front();
                if (o_rsp.result_real !== e.result_real ||
                    o_rsp.result_imag !== e.result_imag || o_rsp.status !== e.status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected re %0d im %0d st %0d, got re %0d im %0d st %0d",
                                 e.result_real, e.result_imag, e.status,
                                 o_rsp.result_real, o_rsp.result_imag, o_rsp.status);
                end
            end
        end
    end

    initial begin
        wait (gen_done);
        wait (pending_reqs.size() == 0 && expected_rsps.size() == 0);
        repeat (40) @(posedge i_clk);
        if (mismatches == 0 && expected_rsps.size() == 0)
            $display("** complex_arithmetic_unit: PASSED **");
        else
            $display("** complex_arithmetic_unit: FAILED **");
        $finish;
    end

    initial begin
        #400000;
        $display("** complex_arithmetic_unit: FAILED **");
        $finish;
    end

endmodule

/* files.f */
sv/cau_pkg.sv
sv/cau_front.sv
sv/cau_cell.sv
sv/cau_back.sv
sv/complex_arithmetic_unit.sv
sv/cau_checker.sv
tb/sv/tb_complex_arithmetic_unit.sv
